@@ hw/rtl/ffsa_pkg.sv @@
// ---------------------------------------------------------------------------
// ffsa_pkg
// shared constants, status codes and controller/datapath interface types
// ---------------------------------------------------------------------------
package ffsa_pkg;

    localparam int MaxSegmentsDefault = 16;
    localparam int AddrW   = 27;
    localparam int PitchW  = 15;
    localparam int RowsW   = 13;
    localparam int StatusW = 3;

    localparam logic [PitchW-1:0] ScreenPitchReset = 15'd7680;

    localparam logic [1:0] RegScreenPitch = 2'd0;
    localparam logic [1:0] RegPoolStart   = 2'd1;
    localparam logic [1:0] RegPoolBytes   = 2'd2;

    localparam logic OpAlloc = 1'b0;
    localparam logic OpFree  = 1'b1;

    localparam logic [StatusW-1:0] StOk         = 3'd0;
    localparam logic [StatusW-1:0] StTooWide    = 3'd1;
    localparam logic [StatusW-1:0] StNoMemory   = 3'd2;
    localparam logic [StatusW-1:0] StFragmented = 3'd3;
    localparam logic [StatusW-1:0] StTableFull  = 3'd4;
    localparam logic [StatusW-1:0] StFreeIgnore = 3'd5;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_LOAD,
        CMD_CHECK,
        CMD_SCAN_START,
        CMD_SCAN_STEP,
        CMD_SHIFT_UP,
        CMD_SPLIT,
        CMD_GRANT,
        CMD_FREE_MARK,
        CMD_SHIFT_DOWN,
        CMD_MERGE_NEXT,
        CMD_MERGE_PREV,
        CMD_REJECT
    } cmd_t;

    typedef struct packed {
        logic                too_wide;
        logic                no_memory;
        logic                hit;
        logic                scan_done;
        logic                need_split;
        logic                table_full;
        logic                shift_done;
        logic                next_free;
        logic                prev_free;
        logic                op;
    } dp_status_t;

endpackage

@@ hw/rtl/ffsa_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffsa_ctrl
// sequencer for allocate and free requests over the segment table
// ---------------------------------------------------------------------------
module ffsa_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                init_req,
    input  logic                out_busy,
    input  ffsa_pkg::dp_status_t st,
    output ffsa_pkg::cmd_t      cmd,
    output logic [ffsa_pkg::StatusW-1:0] rej_code,
    output logic                idle,
    output logic                done
);
    import ffsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SCAN, S_SPLIT_SHIFT, S_SPLIT, S_GRANT,
        S_FREE_SCAN, S_FREE_MARK, S_MN_SHIFT, S_MERGE_PREV, S_MP_SHIFT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [StatusW-1:0] rej_reg, rej_next;

    always_comb
    begin
        state_next = state_reg;
        rej_next   = rej_reg;
        cmd        = CMD_NONE;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (init_req)
                    cmd = CMD_INIT;
                else if (in_fire)
                begin
                    cmd = CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.op == OpFree)
                begin
                    cmd = CMD_SCAN_START;
                    state_next = S_FREE_SCAN;
                end
                else if (st.too_wide)
                begin
                    rej_next = StTooWide;
                    state_next = S_DONE;
                end
                else if (st.no_memory)
                begin
                    rej_next = StNoMemory;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd = CMD_SCAN_START;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.hit)
                begin
                    if (st.need_split && st.table_full)
                    begin
                        rej_next = StTableFull;
                        state_next = S_DONE;
                    end
                    else if (st.need_split)
                        state_next = S_SPLIT_SHIFT;
                    else
                        state_next = S_GRANT;
                end
                else if (st.scan_done)
                begin
                    rej_next = StFragmented;
                    state_next = S_DONE;
                end
                else
                    cmd = CMD_SCAN_STEP;
            end
            S_SPLIT_SHIFT:
            begin
                if (st.shift_done)
                    state_next = S_SPLIT;
                else
                    cmd = CMD_SHIFT_UP;
            end
            S_SPLIT:
            begin
                cmd = CMD_SPLIT;
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                cmd = CMD_GRANT;
                rej_next = StOk;
                state_next = S_DONE;
            end
            S_FREE_SCAN:
            begin
                if (st.hit)
                    state_next = S_FREE_MARK;
                else if (st.scan_done)
                begin
                    rej_next = StFreeIgnore;
                    state_next = S_DONE;
                end
                else
                    cmd = CMD_SCAN_STEP;
            end
            S_FREE_MARK:
            begin
                cmd = CMD_FREE_MARK;
                rej_next = StOk;
                if (st.next_free)
                    state_next = S_MN_SHIFT;
                else
                    state_next = S_MERGE_PREV;
            end
            S_MN_SHIFT:
            begin
                if (st.shift_done)
                    state_next = S_MERGE_PREV;
                else
                    cmd = CMD_SHIFT_DOWN;
            end
            S_MERGE_PREV:
            begin
                if (st.prev_free)
                begin
                    cmd = CMD_MERGE_PREV;
                    state_next = S_MP_SHIFT;
                end
                else
                    state_next = S_DONE;
            end
            S_MP_SHIFT:
            begin
                if (st.shift_done)
                    state_next = S_DONE;
                else
                    cmd = CMD_SHIFT_DOWN;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    done = 1'b1;
                    if (rej_reg != StOk)
                        cmd = CMD_REJECT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_FREE_MARK && st.next_free)
            cmd = CMD_MERGE_NEXT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rej_reg   <= StOk;
        end
        else
        begin
            state_reg <= state_next;
            rej_reg   <= rej_next;
        end
    end

    assign idle     = (state_reg == S_IDLE);
    assign rej_code = rej_reg;

endmodule

@@ hw/rtl/ffsa_datapath.sv @@
// ---------------------------------------------------------------------------
// ffsa_datapath
// segment table, scan pointer, shifter, multiplier and result registers
// ---------------------------------------------------------------------------
module ffsa_datapath
#(
    parameter int MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDefault
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffsa_pkg::cmd_t                cmd,
    input  logic [ffsa_pkg::StatusW-1:0]  rej_code,
    input  logic                          op,
    input  logic [ffsa_pkg::RowsW-1:0]    surface_rows,
    input  logic [ffsa_pkg::PitchW-1:0]   surface_pitch,
    input  logic [ffsa_pkg::AddrW-1:0]    free_base,
    input  logic [ffsa_pkg::PitchW-1:0]   screen_pitch,
    input  logic [ffsa_pkg::AddrW-1:0]    pool_start,
    input  logic [ffsa_pkg::AddrW-1:0]    pool_bytes,
    output ffsa_pkg::dp_status_t          st,
    output logic [ffsa_pkg::StatusW-1:0]  res_status,
    output logic [ffsa_pkg::AddrW-1:0]    res_base,
    output logic [ffsa_pkg::AddrW-1:0]    res_bytes,
    output logic [ffsa_pkg::AddrW-1:0]    res_left
);
    import ffsa_pkg::*;

    localparam int IdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CntW = $clog2(MAX_SEGMENTS + 1);
    localparam int NeedW = RowsW + PitchW;

    logic [AddrW-1:0] base_reg [MAX_SEGMENTS];
    logic [AddrW-1:0] size_reg [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] used_reg;
    logic [CntW-1:0] count_reg;
    logic [AddrW-1:0] total_reg;

    logic             op_reg;
    logic [NeedW-1:0] need_reg;
    logic             wide_reg;
    logic [AddrW-1:0] fbase_reg;
    logic [CntW-1:0]  ptr_reg;
    logic [CntW-1:0]  sh_reg;
    logic [AddrW-1:0] size_w;
    logic [IdxW-1:0]  pi, pn, pp, si;

    assign size_w = need_reg[AddrW-1:0];
    assign pi = ptr_reg[IdxW-1:0];
    assign pn = IdxW'(ptr_reg + 1'b1);
    assign pp = IdxW'(ptr_reg - 1'b1);
    assign si = sh_reg[IdxW-1:0];

    logic in_range, match;
    assign in_range = ptr_reg < count_reg;
    always_comb
    begin
        match = 1'b0;
        if (in_range)
        begin
            if (op_reg == OpFree)
                match = used_reg[pi] && base_reg[pi] == fbase_reg;
            else
                match = !used_reg[pi] && size_w <= size_reg[pi];
        end
    end

    always_comb
    begin
        st = '0;
        st.op         = op_reg;
        st.too_wide   = wide_reg;
        st.no_memory  = need_reg > NeedW'(total_reg);
        st.hit        = match;
        st.scan_done  = !in_range;
        st.need_split = size_reg[pi] != size_w;
        st.table_full = count_reg >= CntW'(MAX_SEGMENTS);
        st.next_free  = (CntW'(ptr_reg + 1'b1) < count_reg) && !used_reg[pn];
        st.prev_free  = (ptr_reg != '0) && !used_reg[pp];
        if (op_reg == OpAlloc)
            st.shift_done = sh_reg <= CntW'(ptr_reg + 1'b1);
        else
            st.shift_done = sh_reg >= count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            count_reg <= '0;
            total_reg <= '0;
            for (int k = 0; k < MAX_SEGMENTS; k++)
            begin
                base_reg[k] <= '0;
                size_reg[k] <= '0;
            end
        end
        else
        begin
            case (cmd)
                CMD_INIT:
                begin
                    used_reg    <= '0;
                    base_reg[0] <= pool_start;
                    size_reg[0] <= pool_bytes;
                    count_reg   <= (pool_bytes != '0) ? CntW'(1) : CntW'(0);
                    total_reg   <= pool_bytes;
                end
                CMD_SHIFT_UP:
                begin
                    base_reg[si] <= base_reg[IdxW'(sh_reg - 1'b1)];
                    size_reg[si] <= size_reg[IdxW'(sh_reg - 1'b1)];
                    used_reg[si] <= used_reg[IdxW'(sh_reg - 1'b1)];
                end
                CMD_SPLIT:
                begin
                    base_reg[pn] <= base_reg[pi] + size_w;
                    size_reg[pn] <= size_reg[pi] - size_w;
                    used_reg[pn] <= 1'b0;
                    count_reg    <= CntW'(count_reg + 1'b1);
                end
                CMD_GRANT:
                begin
                    used_reg[pi] <= 1'b1;
                    size_reg[pi] <= size_w;
                    total_reg    <= total_reg - size_w;
                end
                CMD_FREE_MARK:
                begin
                    used_reg[pi] <= 1'b0;
                    total_reg    <= total_reg + size_reg[pi];
                end
                CMD_MERGE_NEXT:
                begin
                    used_reg[pi] <= 1'b0;
                    total_reg    <= total_reg + size_reg[pi];
                    size_reg[pi] <= size_reg[pi] + size_reg[pn];
                    count_reg    <= CntW'(count_reg - 1'b1);
                end
                CMD_MERGE_PREV:
                begin
                    size_reg[pp] <= size_reg[pp] + size_reg[pi];
                    count_reg    <= CntW'(count_reg - 1'b1);
                end
                CMD_SHIFT_DOWN:
                begin
                    base_reg[si] <= base_reg[IdxW'(sh_reg + 1'b1)];
                    size_reg[si] <= size_reg[IdxW'(sh_reg + 1'b1)];
                    used_reg[si] <= used_reg[IdxW'(sh_reg + 1'b1)];
                end
                default:
                begin
                end
            endcase
        end
    end

    // request capture, scan pointer, shift cursor and result registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                op_reg    <= op;
                fbase_reg <= free_base;
                wide_reg  <= surface_pitch > screen_pitch;
                need_reg  <= NeedW'(surface_rows) * NeedW'(screen_pitch);
            end
            CMD_SCAN_START:
                ptr_reg <= '0;
            CMD_SCAN_STEP:
                ptr_reg <= CntW'(ptr_reg + 1'b1);
            CMD_MERGE_NEXT:
                sh_reg <= CntW'(ptr_reg + 1'b1);
            CMD_MERGE_PREV:
            begin
                sh_reg  <= ptr_reg;
                ptr_reg <= CntW'(ptr_reg - 1'b1);
            end
            CMD_SHIFT_UP:
                sh_reg <= CntW'(sh_reg - 1'b1);
            CMD_SHIFT_DOWN:
                sh_reg <= CntW'(sh_reg + 1'b1);
            default:
            begin
            end
        endcase
        if (cmd == CMD_SCAN_STEP || cmd == CMD_SCAN_START)
            sh_reg <= count_reg;
        if (cmd == CMD_GRANT)
        begin
            res_base  <= base_reg[pi];
            res_bytes <= size_w;
            res_left  <= total_reg - size_w;
        end
        else if (cmd == CMD_FREE_MARK || cmd == CMD_MERGE_NEXT)
        begin
            res_base  <= base_reg[pi];
            res_bytes <= size_reg[pi];
            res_left  <= total_reg + size_reg[pi];
        end
        else if (cmd == CMD_REJECT || cmd == CMD_LOAD)
        begin
            res_base  <= '0;
            res_bytes <= '0;
            res_left  <= total_reg;
        end
    end

    assign res_status = rej_code;

endmodule

@@ hw/rtl/first_fit_segment_allocator_unit.sv @@
// ---------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// first-fit video memory allocator with coalescing on free
// ---------------------------------------------------------------------------
// s_axis carries one request word: op selects allocate or free; surface_rows
// and screen_pitch size an allocation, free_base names the segment to free.
// m_axis returns one result word per request: status, granted base and bytes,
// and the free bytes left in the pool.
// A request takes a check and a completion step plus one step per segment
// scanned, per table entry shifted and per split or merge step; the serial scan
// and the one-entry-a-cycle table shifter set its duration. The next word can
// be accepted in the same cycle that the result appears on m_axis.
// One request is in flight at a time. The result sits in an output register;
// while the receiver stalls it holds there and the next request is taken but
// waits to finish until that word leaves.
// Reset leaves screen_pitch at 7680 and an empty pool; writing pool_bytes
// over APB rebuilds the table as one free segment at pool_start.
// ---------------------------------------------------------------------------
module first_fit_segment_allocator_unit
#(
    parameter int MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // op, surface_rows, surface_pitch, free_base
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // status, granted_base, granted_bytes, bytes_left
);
    import ffsa_pkg::*;

    logic [PitchW-1:0] pitch_reg;
    logic [AddrW-1:0]  start_reg;
    logic [AddrW-1:0]  bytes_reg;
    logic              init_pend_reg;
    logic              wr;
    logic [1:0]        ridx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[3:2];

    cmd_t       cmd;
    dp_status_t st;
    logic [StatusW-1:0] rej_code, res_status;
    logic [AddrW-1:0]   res_base, res_bytes, res_left;
    logic idle, done, ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg     <= ScreenPitchReset;
            start_reg     <= '0;
            bytes_reg     <= '0;
            init_pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd == CMD_INIT)
                init_pend_reg <= 1'b0;
            if (wr && paddr[1:0] == 2'b00)
            begin
                case (ridx)
                    RegScreenPitch: pitch_reg <= pwdata[PitchW-1:0];
                    RegPoolStart:   start_reg <= pwdata[AddrW-1:0];
                    RegPoolBytes:
                    begin
                        bytes_reg     <= pwdata[AddrW-1:0];
                        init_pend_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        case (ridx)
            RegScreenPitch: prdata = {17'd0, pitch_reg};
            RegPoolStart:   prdata = {5'd0, start_reg};
            RegPoolBytes:   prdata = {5'd0, bytes_reg};
            default:        prdata = '0;
        endcase
    end

    assign s_axis_tready = idle && !init_pend_reg;

    ffsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid && s_axis_tready),
        .init_req (init_pend_reg),
        .out_busy (ovalid_reg && !m_axis_tready),
        .st       (st),
        .cmd      (cmd),
        .rej_code (rej_code),
        .idle     (idle),
        .done     (done)
    );

    ffsa_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rej_code      (rej_code),
        .op            (s_axis_tdata[0]),
        .surface_rows  (s_axis_tdata[13:1]),
        .surface_pitch (s_axis_tdata[28:14]),
        .free_base     (s_axis_tdata[55:29]),
        .screen_pitch  (pitch_reg),
        .pool_start    (start_reg),
        .pool_bytes    (bytes_reg),
        .st            (st),
        .res_status    (res_status),
        .res_base      (res_base),
        .res_bytes     (res_bytes),
        .res_left      (res_left)
    );

    logic [83:0] out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (done)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_reg <= {res_left, res_bytes, res_base, res_status};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'd0, out_reg};

endmodule
